// File: hdl/csr_pkg.sv
// Shared types and constants for the cosine similarity ranker.
// Used by csr_ctrl, csr_dp and cosine_similarity_ranker.
package csr_pkg;
	localparam int MaxElements = 1024;
	localparam int MaxCandidates = 64;
	localparam int ValueWidth = 24;
	localparam int LenWidth = 11;
	localparam int AccWidth = 64;
	localparam int SimWidth = 16;
	localparam int IdxWidth = 6;
	localparam logic [LenWidth-1:0] LenReset = 11'd531;

	localparam logic [1:0] ModeQuery = 2'd0;
	localparam logic [1:0] ModeCand = 2'd1;
	localparam logic [1:0] ModeEmit = 2'd2;
	localparam logic [1:0] ModeClear = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic acc_q;      // query element: store, clear accumulators
		logic acc_c;      // candidate element: accumulate
		logic start_sqrt; // start the roots of the two norms
		logic start_div;  // start the divide
		logic ins_start;  // begin sorted insert
		logic ins_step;   // shift one list entry
		logic clear;      // clear list, accumulators and position
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic ins_done;
		logic full;
	} sts_t;
endpackage

// File: hdl/cosine_similarity_ranker.sv
// Top level of the cosine similarity ranker.
// Instantiates csr_ctrl and csr_dp; uses csr_pkg.
//
// Usage: load a query with mode 0 items, vector_length of them. Then send
// candidates as mode 1 items of the same length. Each element is one
// transfer on the input channel (valid/stall); while a candidate streams
// the block takes one element per cycle. At the last element of a
// candidate the input stalls while the block drains the multiply pipeline,
// takes the bit-serial roots of both norms (32 steps) and their product, runs
// the 81-step restoring divide and does the sorted insert, one entry shifted
// at a time; a full list drops the candidate. Mode 2 (emit) gives one output
// transfer per ranked candidate, the last marked by last_rank; an empty list
// gives one transfer with list_empty set. Mode 3 clears the list, accumulators
// and element position, not the query memory or vector_length. A stall on the
// output holds the result in the output register and the emit sequencer.
// After reset the list is empty, vector_length is 531 and the query memory
// is undefined until written. vector_length is written on its own valid/ready
// channel; the user must write it only while idle, not enforced by the block.
module cosine_similarity_ranker #(
	parameter int MAX_ELEMENTS = csr_pkg::MaxElements,
	parameter int MAX_CANDIDATES = csr_pkg::MaxCandidates,
	parameter int VALUE_WIDTH = csr_pkg::ValueWidth
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] mode,
	input logic signed [VALUE_WIDTH-1:0] element_value,
	output logic out_valid,
	input logic out_stall,
	output logic [5:0] rank_index,
	output logic signed [15:0] similarity,
	output logic last_rank,
	output logic overflowed,
	output logic list_empty,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [csr_pkg::LenWidth-1:0] cfg_data
);
	csr_pkg::cmd_t cmd;
	csr_pkg::sts_t sts;
	logic [csr_pkg::LenWidth-1:0] len_q;
	logic [csr_pkg::IdxWidth:0] emit_ptr, count;
	logic [csr_pkg::IdxWidth-1:0] rd_index;
	logic [csr_pkg::SimWidth-1:0] rd_sim;
	logic ovf, vec_end, rd_ok, rd_last, rd_empty, out_busy;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= csr_pkg::LenReset;
		end else if (cfg_valid && cfg_ready) begin
			len_q <= cfg_data;
		end
	end

	// output register: busy while holding an untaken result
	assign out_busy = out_valid && out_stall;

	csr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .vec_end(vec_end), .sts(sts), .cmd(cmd), .count(count),
		.emit_ptr(emit_ptr), .rd_ok(rd_ok), .rd_last(rd_last),
		.rd_empty(rd_empty), .out_busy(out_busy)
	);

	csr_dp #(
		.MAX_ELEMENTS(MAX_ELEMENTS), .MAX_CANDIDATES(MAX_CANDIDATES),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .len(len_q),
		.value(element_value), .emit_ptr(emit_ptr), .rd_index(rd_index),
		.rd_sim(rd_sim), .count(count), .ovf(ovf), .vec_end(vec_end)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rd_ok) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (rd_ok) begin
			rank_index <= rd_empty ? '0 : rd_index;
			similarity <= rd_empty ? '0 : rd_sim;
			last_rank <= rd_empty ? 1'b0 : rd_last;
			overflowed <= rd_empty ? 1'b0 : ovf;
			list_empty <= rd_empty;
		end
	end
endmodule

// File: hdl/csr_dp.sv
// Datapath of the cosine similarity ranker: query memory, accumulators,
// bit-serial root and divide units, ranked list. Depends on csr_pkg.
module csr_dp #(
	parameter int MAX_ELEMENTS = csr_pkg::MaxElements,
	parameter int MAX_CANDIDATES = csr_pkg::MaxCandidates,
	parameter int VALUE_WIDTH = csr_pkg::ValueWidth
) (
	input logic clk,
	input logic arst_n,
	input csr_pkg::cmd_t cmd,
	output csr_pkg::sts_t sts,
	input logic [csr_pkg::LenWidth-1:0] len,
	input logic [VALUE_WIDTH-1:0] value,
	input logic [csr_pkg::IdxWidth:0] emit_ptr,
	output logic [csr_pkg::IdxWidth-1:0] rd_index,
	output logic [csr_pkg::SimWidth-1:0] rd_sim,
	output logic [csr_pkg::IdxWidth:0] count,
	output logic ovf,
	output logic vec_end
);
	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = csr_pkg::IdxWidth + 1;
	localparam int W = csr_pkg::AccWidth;
	localparam int PW = 2 * VALUE_WIDTH;
	localparam int RW = W / 2;
	localparam logic [csr_pkg::SimWidth-1:0] SimMax = 16'h7fff;
	localparam logic [csr_pkg::SimWidth-1:0] SimMin = 16'h8000;

	logic [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];
	logic [AW:0] pos_q;
	logic [AW:0] pos_c;
	logic [AW:0] len_e;
	logic [VALUE_WIDTH-1:0] qv_s1;
	logic [VALUE_WIDTH-1:0] cv_s1;
	logic acc_s1;
	logic [PW-1:0] pd_s2;
	logic [PW-1:0] pq_s2;
	logic [PW-1:0] pc_s2;
	logic acc_s2;
	logic [W-1:0] dot_q;
	logic [W-1:0] qn_q;
	logic [W-1:0] cn_q;

	// clamp length to 1..MAX_ELEMENTS
	always_comb begin
		if (len == '0) begin
			len_e = (AW+1)'(1);
		end else if (32'(len) > MAX_ELEMENTS) begin
			len_e = (AW+1)'(MAX_ELEMENTS);
		end else begin
			len_e = (AW+1)'(len);
		end
		pos_c = (32'(pos_q) >= MAX_ELEMENTS) ? (AW+1)'(MAX_ELEMENTS - 1) : pos_q;
	end
	assign vec_end = (pos_c + 1'b1) >= len_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.clear) begin
			pos_q <= '0;
		end else if (cmd.acc_q || cmd.acc_c) begin
			pos_q <= vec_end ? '0 : pos_c + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_q) begin
			mem[pos_c[AW-1:0]] <= value;
		end
		qv_s1 <= mem[pos_c[AW-1:0]];
		cv_s1 <= value;
	end

	// a query element drops candidate products still in the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0; acc_s2 <= 1'b0;
		end else begin
			acc_s1 <= cmd.acc_c && !cmd.clear;
			acc_s2 <= acc_s1 && !cmd.clear && !cmd.acc_q;
		end
	end

	always_ff @(posedge clk) begin
		pd_s2 <= PW'($signed(qv_s1) * $signed(cv_s1));
		pq_s2 <= PW'($signed(qv_s1) * $signed(qv_s1));
		pc_s2 <= PW'($signed(cv_s1) * $signed(cv_s1));
	end

	// accumulators; cleared at vector end once the norms are latched by sqrt
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0; qn_q <= '0; cn_q <= '0;
		end else if (cmd.clear || cmd.acc_q) begin
			dot_q <= '0; qn_q <= '0; cn_q <= '0;
		end else if (cmd.start_sqrt) begin
			dot_q <= '0; qn_q <= '0; cn_q <= '0;
		end else if (acc_s2) begin
			dot_q <= dot_q + W'($signed(pd_s2));
			qn_q <= qn_q + W'(pq_s2);
			cn_q <= cn_q + W'(pc_s2);
		end
	end

	// two bit-serial roots in parallel, one result bit per cycle
	logic [W-1:0] rq_v_q, rc_v_q, rq_r_q, rc_r_q, rq_b_q, rc_b_q;
	logic [W-1:0] mag_q;
	logic neg_q;
	logic zero_q;
	logic sq_busy_q;
	logic sq_done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0; sq_done_q <= 1'b0;
		end else if (cmd.clear) begin
			sq_busy_q <= 1'b0; sq_done_q <= 1'b0;
		end else begin
			sq_done_q <= 1'b0;
			if (cmd.start_sqrt) begin
				sq_busy_q <= 1'b1;
			end else if (sq_busy_q && rq_b_q == '0) begin
				sq_busy_q <= 1'b0; sq_done_q <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.start_sqrt) begin
			rq_v_q <= qn_q; rc_v_q <= cn_q; rq_r_q <= '0; rc_r_q <= '0;
			rq_b_q <= W'(1) << (W - 2); rc_b_q <= W'(1) << (W - 2);
			neg_q <= dot_q[W-1];
			mag_q <= dot_q[W-1] ? (W'(0) - dot_q) : dot_q;
			zero_q <= (qn_q == '0) || (cn_q == '0);
		end else if (sq_busy_q && rq_b_q != '0) begin
			if (rq_v_q >= rq_r_q + rq_b_q) begin
				rq_v_q <= rq_v_q - (rq_r_q + rq_b_q);
				rq_r_q <= (rq_r_q >> 1) + rq_b_q;
			end else begin
				rq_r_q <= rq_r_q >> 1;
			end
			if (rc_v_q >= rc_r_q + rc_b_q) begin
				rc_v_q <= rc_v_q - (rc_r_q + rc_b_q);
				rc_r_q <= (rc_r_q >> 1) + rc_b_q;
			end else begin
				rc_r_q <= rc_r_q >> 1;
			end
			rq_b_q <= rq_b_q >> 2; rc_b_q <= rc_b_q >> 2;
		end
	end

	// denominator product: 32x32, registered
	logic [W-1:0] den_q;
	logic den_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_v_q <= 1'b0;
		end else begin
			den_v_q <= sq_done_q && !cmd.clear;
		end
	end
	always_ff @(posedge clk) begin
		den_q <= W'(rq_r_q[RW-1:0]) * W'(rc_r_q[RW-1:0]);
	end
	assign sts.sqrt_done = den_v_q;

	// restoring divide: mag*2^16/den, one spare bit below q15 for rounding
	localparam int DN = W + 17;
	localparam int SimWidthL = 18;
	logic [DN-1:0] num_q;
	logic [W:0] rem_q;
	logic [6:0] dcnt_q;
	logic dbusy_q;
	logic ddone_q;
	logic [W:0] rtry;
	logic [SimWidthL-1:0] qres;
	logic [csr_pkg::SimWidth-1:0] sim_res;
	assign rtry = {rem_q[W-1:0], num_q[DN-1]} - {1'b0, den_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0; ddone_q <= 1'b0;
		end else if (cmd.clear) begin
			dbusy_q <= 1'b0; ddone_q <= 1'b0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.start_div) begin
				dbusy_q <= 1'b1;
			end else if (dbusy_q && dcnt_q == 7'(DN - 1)) begin
				dbusy_q <= 1'b0; ddone_q <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			num_q <= {1'b0, mag_q, 16'd0}; rem_q <= '0; dcnt_q <= '0;
		end else if (dbusy_q) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (!rtry[W]) begin
				rem_q <= rtry; num_q <= {num_q[DN-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-1:0], num_q[DN-1]}; num_q <= {num_q[DN-2:0], 1'b0};
			end
		end
	end
	// num_q now holds floor(mag*2^16/den); round half up on q15
	logic big;
	assign big = num_q[DN-1:17] != '0;
	assign qres = {1'b0, num_q[16:0]} + 18'd1;
	always_comb begin
		if (zero_q || den_q == '0) begin
			sim_res = '0;
		end else if (neg_q) begin
			sim_res = (big || qres[17:1] >= 17'd32768) ? SimMin
				: csr_pkg::SimWidth'(17'd0 - qres[17:1]);
		end else begin
			sim_res = (big || qres[17:1] >= 17'd32767) ? SimMax
				: csr_pkg::SimWidth'(qres[17:1]);
		end
	end
	assign sts.div_done = ddone_q;

	// ranked list: sorted insert, shifting entries one at a time from the tail
	logic [csr_pkg::SimWidth-1:0] sc_q [MAX_CANDIDATES];
	logic [csr_pkg::IdxWidth-1:0] ix_q [MAX_CANDIDATES];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ip_q;
	logic [csr_pkg::SimWidth-1:0] new_q;
	logic ovf_q;
	logic [csr_pkg::SimWidth-1:0] prev_sc;
	logic [csr_pkg::IdxWidth-1:0] prev_ix;
	logic [csr_pkg::SimWidth-1:0] sc_rd;
	logic [csr_pkg::IdxWidth-1:0] ix_rd;
	logic ins_here;
	localparam int LW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	always_ff @(posedge clk) begin
		prev_sc <= sc_q[LW'(ip_q - 1'b1)];
		prev_ix <= ix_q[LW'(ip_q - 1'b1)];
	end
	assign sts.full = 32'(cnt_q) >= MAX_CANDIDATES;
	logic ins_busy_q, ins_rd_q, ins_done_q;
	assign ins_here = (ip_q == '0) || ($signed(prev_sc) >= $signed(new_q));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; ovf_q <= 1'b0; ins_busy_q <= 1'b0;
			ins_rd_q <= 1'b0; ins_done_q <= 1'b0;
		end else if (cmd.clear) begin
			cnt_q <= '0; ovf_q <= 1'b0; ins_busy_q <= 1'b0;
			ins_rd_q <= 1'b0; ins_done_q <= 1'b0;
		end else begin
			ins_done_q <= 1'b0;
			ins_rd_q <= 1'b0;
			if (cmd.ins_start) begin
				if (sts.full) begin
					ovf_q <= 1'b1; ins_done_q <= 1'b1;
				end else begin
					ins_busy_q <= 1'b1; ins_rd_q <= 1'b1;
				end
			end else if (ins_busy_q && !ins_rd_q) begin
				if (ins_here) begin
					ins_busy_q <= 1'b0; ins_done_q <= 1'b1; cnt_q <= cnt_q + 1'b1;
				end else begin
					ins_rd_q <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.ins_start) begin
			ip_q <= cnt_q; new_q <= sim_res;
		end else if (ins_busy_q && !ins_rd_q) begin
			if (ins_here) begin
				sc_q[LW'(ip_q)] <= new_q; ix_q[LW'(ip_q)] <= csr_pkg::IdxWidth'(cnt_q);
			end else begin
				sc_q[LW'(ip_q)] <= prev_sc; ix_q[LW'(ip_q)] <= prev_ix;
				ip_q <= ip_q - 1'b1;
			end
		end
		sc_rd <= sc_q[LW'(emit_ptr)];
		ix_rd <= ix_q[LW'(emit_ptr)];
	end
	assign sts.ins_done = ins_done_q;
	assign rd_sim = sc_rd;
	assign rd_index = ix_rd;
	assign count = cnt_q;
	assign ovf = ovf_q;
endmodule

// File: hdl/csr_ctrl.sv
// Controller of the cosine similarity ranker: sequences accumulate,
// roots, divide, insert and emit. Depends on csr_pkg.
module csr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] mode,
	input logic vec_end,
	input csr_pkg::sts_t sts,
	output csr_pkg::cmd_t cmd,
	input logic [csr_pkg::IdxWidth:0] count,
	output logic [csr_pkg::IdxWidth:0] emit_ptr,
	output logic rd_ok,
	output logic rd_last,
	output logic rd_empty,
	input logic out_busy
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StDrain = 3'd1;
	localparam logic [2:0] StSqrt = 3'd2;
	localparam logic [2:0] StDiv = 3'd3;
	localparam logic [2:0] StIns = 3'd4;
	localparam logic [2:0] StEmit = 3'd5;

	logic [2:0] st_q;
	logic [1:0] dr_q;
	logic [csr_pkg::IdxWidth:0] ep_q;
	logic rdv_q;
	logic acc;

	assign in_stall = st_q != StIdle;
	assign acc = in_valid && !in_stall;
	assign emit_ptr = ep_q;

	always_comb begin
		cmd = '0;
		cmd.acc_q = acc && mode == csr_pkg::ModeQuery;
		cmd.acc_c = acc && mode == csr_pkg::ModeCand;
		cmd.clear = acc && mode == csr_pkg::ModeClear;
		cmd.start_sqrt = st_q == StDrain && dr_q == 2'd0;
		cmd.start_div = st_q == StSqrt && sts.sqrt_done;
		cmd.ins_start = st_q == StDiv && sts.div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle; dr_q <= '0; ep_q <= '0; rdv_q <= 1'b0;
		end else begin
			case (st_q)
				StIdle: begin
					if (cmd.acc_c && vec_end) begin
						st_q <= StDrain; dr_q <= 2'd2;
					end else if (acc && mode == csr_pkg::ModeEmit) begin
						st_q <= StEmit; ep_q <= '0; rdv_q <= 1'b0;
					end
				end
				StDrain: begin
					if (dr_q == 2'd0) begin
						st_q <= StSqrt;
					end else begin
						dr_q <= dr_q - 1'b1;
					end
				end
				StSqrt: if (sts.sqrt_done) st_q <= StDiv;
				StDiv: if (sts.div_done) st_q <= StIns;
				StIns: if (sts.ins_done) st_q <= StIdle;
				StEmit: begin
					// rdv_q: read data for ep_q is registered and ready
					if (!rdv_q) begin
						rdv_q <= 1'b1;
					end else if (!out_busy) begin
						rdv_q <= 1'b0;
						if (count == '0 || ep_q + 1'b1 >= count) begin
							st_q <= StIdle;
						end else begin
							ep_q <= ep_q + 1'b1;
						end
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end
	assign rd_ok = st_q == StEmit && rdv_q && !out_busy;
	assign rd_last = ep_q + 1'b1 >= count;
	assign rd_empty = count == '0;

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == StSqrt) |-> in_stall) else $error("accept during root");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == StEmit && count != '0) |-> ep_q < count) else $error("emit past list");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc_c && vec_end) |=> st_q == StDrain) else $error("no drain");
endmodule
